/* rtl/search_result_cache_defines.svh */
// assertion macros for the search result cache
`ifndef SEARCH_RESULT_CACHE_DEFINES_SVH
`define SEARCH_RESULT_CACHE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define SRC_ASSERT(label, prop, msg)
`define SRC_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

/* rtl/src_pkg.sv */
// shared types, codes and helpers of the search result cache
package src_pkg;

  localparam int INDEX_BITS  = 16;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;
  localparam int ALU_W       = 18;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef logic [INDEX_BITS-1:0]   index_t;
  typedef logic signed [ALU_W-1:0] alu_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [7:0]  depth;
    logic [7:0]  generation;
    logic [6:0]  fifty;
    logic [7:0]  castling;
    logic [15:0] score;
    logic [15:0] eval;
    logic [31:0] move;
    logic [1:0]  bound;
  } entry_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } alu_flags_t;

  localparam logic OP_PROBE = 1'b0;
  localparam logic OP_STORE = 1'b1;

  localparam logic [1:0] BOUND_UPPER = 2'd0;
  localparam logic [1:0] BOUND_LOWER = 2'd1;
  localparam logic [1:0] BOUND_EXACT = 2'd2;

  localparam logic [2:0] CODE_NONE       = 3'd0;
  localparam logic [2:0] CODE_AVOID_NULL = 3'd1;
  localparam logic [2:0] CODE_UPPER      = 3'd2;
  localparam logic [2:0] CODE_LOWER      = 3'd3;
  localparam logic [2:0] CODE_EXACT      = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_GENERATION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATE_HIGH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATE_LOW   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_NULL_RED   = 2'd3;

  localparam alu_t SAT_MAX = 18'sd32767;
  localparam alu_t SAT_MIN = -18'sd32768;

  function automatic alu_t from_s16(logic [15:0] v);
    return alu_t'({{(ALU_W-16){v[15]}}, v});
  endfunction

  function automatic alu_t from_u8(logic [7:0] v);
    return alu_t'({{(ALU_W-8){1'b0}}, v});
  endfunction

  function automatic logic [15:0] sat16(alu_t v);
    logic [15:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[15:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[15:0];
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

/* rtl/src_if.sv */
// request and response channel interfaces of the search result cache
interface src_req_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [63:0]        position_key;
  logic [6:0]         fifty_count;
  logic [7:0]         castling_state;
  logic [7:0]         search_depth;
  logic [6:0]         ply;
  logic signed [15:0] score;
  logic [1:0]         bound_kind;
  logic [31:0]        best_move;
  logic signed [15:0] static_eval;
  logic signed [15:0] alpha;
  logic signed [15:0] beta;

  modport source (
    output valid, operation, position_key, fifty_count, castling_state, search_depth,
           ply, score, bound_kind, best_move, static_eval, alpha, beta,
    input  ready
  );
  modport sink (
    input  valid, operation, position_key, fifty_count, castling_state, search_depth,
           ply, score, bound_kind, best_move, static_eval, alpha, beta,
    output ready
  );
endinterface

interface src_rsp_if;
  logic               valid;
  logic               ready;
  logic               written;
  logic               hit;
  logic [2:0]         probe_code;
  logic signed [15:0] probe_score;
  logic [31:0]        hit_move;
  logic signed [15:0] hit_static_eval;

  modport source (
    output valid, written, hit, probe_code, probe_score, hit_move, hit_static_eval,
    input  ready
  );
  modport sink (
    input  valid, written, hit, probe_code, probe_score, hit_move, hit_static_eval,
    output ready
  );
endinterface

/* rtl/src_table.sv */
// entry table: one write port, one registered read port
module src_table (
  input  logic            clk,
  input  logic            we,
  input  src_pkg::index_t waddr,
  input  src_pkg::entry_t wdata,
  input  src_pkg::index_t raddr,
  output src_pkg::entry_t rdata
);

  src_pkg::entry_t mem [src_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/src_alu.sv */
// shared subtract and compare unit
module src_alu (
  input  src_pkg::alu_t       a,
  input  src_pkg::alu_t       b,
  output src_pkg::alu_t       diff,
  output src_pkg::alu_flags_t flags
);

  assign diff     = a - b;
  assign flags.lt = diff[src_pkg::ALU_W-1];
  assign flags.eq = (diff == '0);

endmodule

/* rtl/search_result_cache.sv */
// top level of the search result cache
// Direct-mapped table of search results indexed by the low 16 key bits. After reset the
// table is swept once to clear its valid bits, one entry per cycle, with req.ready low;
// configuration writes are taken throughout. Each transaction then runs through one
// table read and a shared 18-bit subtract/compare unit stepped once per cycle: a store
// runs up to the depth compare, then writes its entry unless skipped; a probe runs every
// step through the alpha compare. A finished result waits in the output register while
// the next request is accepted; a result not taken holds the block in its last cycle.
`include "search_result_cache_defines.svh"

module search_result_cache (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [src_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [src_pkg::CFG_DATA_W-1:0]     cfg_data,
  src_req_if.sink                            req,
  src_rsp_if.source                          rsp
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [2:0] STEP_HIGH  = 3'd0;
  localparam logic [2:0] STEP_LOW   = 3'd1;
  localparam logic [2:0] STEP_ADJ   = 3'd2;
  localparam logic [2:0] STEP_DEPTH = 3'd3;
  localparam logic [2:0] STEP_RED   = 3'd4;
  localparam logic [2:0] STEP_NULL  = 3'd5;
  localparam logic [2:0] STEP_BETA  = 3'd6;
  localparam logic [2:0] STEP_ALPHA = 3'd7;

  // configuration
  logic [7:0]  generation;
  logic [15:0] mate_high;
  logic [15:0] mate_low;
  logic [3:0]  null_red;

  always_ff @(posedge clk) begin
    if (rst) begin
      generation <= 8'd0;
      mate_high  <= 16'sd30000;
      mate_low   <= -16'sd30000;
      null_red   <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        src_pkg::CFG_GENERATION: generation <= cfg_data[7:0];
        src_pkg::CFG_MATE_HIGH:  mate_high  <= cfg_data;
        src_pkg::CFG_MATE_LOW:   mate_low   <= cfg_data;
        src_pkg::CFG_NULL_RED:   null_red   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // request capture
  logic               q_op;
  logic [63:0]        q_key;
  logic [6:0]         q_fifty;
  logic [7:0]         q_castling;
  logic [7:0]         q_depth;
  logic [6:0]         q_ply;
  logic [15:0]        q_score;
  logic [1:0]         q_bound;
  logic [31:0]        q_move;
  logic [15:0]        q_eval;
  logic [15:0]        q_alpha;
  logic [15:0]        q_beta;

  logic [2:0]            state;
  logic [2:0]            step;
  src_pkg::index_t       clr_cnt;
  logic                  in_accept;

  assign req.ready = (state == ST_IDLE);
  assign in_accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      q_op       <= req.operation;
      q_key      <= req.position_key;
      q_fifty    <= req.fifty_count;
      q_castling <= req.castling_state;
      q_depth    <= req.search_depth;
      q_ply      <= req.ply;
      q_score    <= req.score;
      q_bound    <= req.bound_kind;
      q_move     <= req.best_move;
      q_eval     <= req.static_eval;
      q_alpha    <= req.alpha;
      q_beta     <= req.beta;
    end
  end

  // table
  logic            mem_we;
  src_pkg::index_t mem_waddr;
  src_pkg::entry_t mem_wdata;
  src_pkg::entry_t rd;
  logic [15:0]     adj_score;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = q_key[src_pkg::INDEX_BITS-1:0];
    mem_wdata = '0;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
    end else if (state == ST_WRITE) begin
      mem_we              = 1'b1;
      mem_wdata.valid     = 1'b1;
      mem_wdata.key       = q_key;
      mem_wdata.depth     = q_depth;
      mem_wdata.generation = generation;
      mem_wdata.fifty     = q_fifty;
      mem_wdata.castling  = q_castling;
      mem_wdata.score     = adj_score;
      mem_wdata.eval      = q_eval;
      mem_wdata.move      = q_move;
      mem_wdata.bound     = q_bound;
    end
  end

  src_table u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (q_key[src_pkg::INDEX_BITS-1:0]),
    .rdata (rd)
  );

  // shared unit
  src_pkg::alu_t       alu_a;
  src_pkg::alu_t       alu_b;
  src_pkg::alu_t       alu_diff;
  src_pkg::alu_flags_t alu_flags;
  logic [15:0]         score_src;
  src_pkg::alu_t       ply_ext;
  src_pkg::alu_t       red_depth;
  logic                hi_q, lo_q, match_q, dge_q, nge_q, vltb_q, vlea_q;

  assign score_src = (q_op == src_pkg::OP_STORE) ? q_score : rd.score;
  assign ply_ext   = src_pkg::from_u8({1'b0, q_ply});

  always_comb begin
    alu_a = src_pkg::from_s16(score_src);
    alu_b = '0;
    unique case (step)
      STEP_HIGH:  alu_b = src_pkg::from_s16(mate_high);
      STEP_LOW:   alu_b = src_pkg::from_s16(mate_low);
      STEP_ADJ: begin
        if (hi_q) begin
          alu_b = (q_op == src_pkg::OP_STORE) ? -ply_ext : ply_ext;
        end else if (lo_q) begin
          alu_b = (q_op == src_pkg::OP_STORE) ? ply_ext : -ply_ext;
        end
      end
      STEP_DEPTH: begin
        alu_a = src_pkg::from_u8(rd.depth);
        alu_b = src_pkg::from_u8(q_depth);
      end
      STEP_RED: begin
        alu_a = src_pkg::from_u8(q_depth);
        alu_b = src_pkg::from_u8({4'd0, null_red});
      end
      STEP_NULL: begin
        alu_a = src_pkg::from_u8(rd.depth);
        alu_b = red_depth;
      end
      STEP_BETA: begin
        alu_a = src_pkg::from_s16(adj_score);
        alu_b = src_pkg::from_s16(q_beta);
      end
      STEP_ALPHA: begin
        alu_a = src_pkg::from_s16(adj_score);
        alu_b = src_pkg::from_s16(q_alpha);
      end
      default: ;
    endcase
  end

  src_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .diff  (alu_diff),
    .flags (alu_flags)
  );

  always_ff @(posedge clk) begin
    if (state == ST_STEP) begin
      unique case (step)
        STEP_HIGH: begin
          hi_q    <= !alu_flags.lt && !alu_flags.eq;
          match_q <= rd.valid && (rd.generation == generation) && (rd.key == q_key) &&
                     (rd.fifty == q_fifty) && (rd.castling == q_castling);
        end
        STEP_LOW:   lo_q      <= alu_flags.lt;
        STEP_ADJ:   adj_score <= src_pkg::sat16(alu_diff);
        STEP_DEPTH: dge_q     <= !alu_flags.lt;
        STEP_RED:   red_depth <= alu_diff;
        STEP_NULL:  nge_q     <= !alu_flags.lt;
        STEP_BETA:  vltb_q    <= alu_flags.lt;
        STEP_ALPHA: vlea_q    <= alu_flags.lt || alu_flags.eq;
        default: ;
      endcase
    end
  end

  // sequencer
  logic out_free;
  logic wrote;
  logic store_skip;

  assign out_free   = !rsp.valid || rsp.ready;
  assign store_skip = match_q && !alu_flags.lt && !alu_flags.eq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      step    <= STEP_HIGH;
      clr_cnt <= '0;
      wrote   <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          step  <= STEP_HIGH;
          wrote <= 1'b0;
          state <= ST_STEP;
        end
        ST_STEP: begin
          step <= step + 1'b1;
          if (q_op == src_pkg::OP_STORE && step == STEP_DEPTH) begin
            state <= store_skip ? ST_DONE : ST_WRITE;
          end else if (step == STEP_ALPHA) begin
            state <= ST_DONE;
          end
        end
        ST_WRITE: begin
          wrote <= 1'b1;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result
  logic        res_hit;
  logic [2:0]  res_code;
  logic [15:0] res_score;
  logic        out_load;

  assign res_hit  = (q_op == src_pkg::OP_PROBE) && match_q;
  assign out_load = (state == ST_DONE) && out_free;

  always_comb begin
    res_code  = src_pkg::CODE_NONE;
    res_score = '0;
    if (nge_q && vltb_q && rd.bound == src_pkg::BOUND_UPPER) begin
      res_code = src_pkg::CODE_AVOID_NULL;
    end
    if (dge_q) begin
      priority if (rd.bound == src_pkg::BOUND_UPPER && vlea_q) begin
        res_code  = src_pkg::CODE_UPPER;
        res_score = q_alpha;
      end else if (rd.bound == src_pkg::BOUND_LOWER && !vltb_q) begin
        res_code  = src_pkg::CODE_LOWER;
        res_score = q_beta;
      end else if (rd.bound == src_pkg::BOUND_EXACT) begin
        res_code  = src_pkg::CODE_EXACT;
        res_score = adj_score;
      end else begin
        res_score = '0;
      end
    end
    if (!res_hit) begin
      res_code  = src_pkg::CODE_NONE;
      res_score = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.written         <= (q_op == src_pkg::OP_STORE) && wrote;
      rsp.hit             <= res_hit;
      rsp.probe_code      <= res_code;
      rsp.probe_score     <= res_score;
      rsp.hit_move        <= res_hit ? rd.move : 32'd0;
      rsp.hit_static_eval <= res_hit ? rd.eval : 16'd0;
    end
  end

  `SRC_ASSERT_IMPL(a_store_write, state == ST_WRITE, q_op == src_pkg::OP_STORE, "stray write")
  `SRC_ASSERT_IMPL(a_accept_reads, in_accept, ##1 state == ST_READ, "no read after accept")
  `SRC_ASSERT_IMPL(a_hit_is_probe, out_load && res_hit, !wrote, "hit with a write")
  `SRC_ASSERT_IMPL(a_clear_complete, $fell(state == ST_CLEAR), clr_cnt == '0, "sweep ended early")
  `SRC_ASSERT(a_ready_free, !(req.ready && state == ST_CLEAR), "ready during sweep")

endmodule

/* tb/tb_search_result_cache.sv */
// self-checking testbench for the search result cache: directed and random probes and stores
module tb_search_result_cache;

  localparam int KEYS        = 32;
  localparam int PHASE_ITEMS = 138;
  localparam int SETTLE      = 20;
  localparam int HOLD_LONG   = 400;
  localparam int STALL_LIMIT = 300000;

  localparam logic [1:0] BOUND_SPARE = 2'd3;

  typedef struct packed {
    logic               op;
    logic [63:0]        key;
    logic [6:0]         fifty;
    logic [7:0]         castling;
    logic [7:0]         depth;
    logic [6:0]         ply;
    logic signed [15:0] score;
    logic [1:0]         bound;
    logic [31:0]        move;
    logic signed [15:0] seval;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
  } lookup_t;

  typedef struct packed {
    logic               written;
    logic               hit;
    logic [2:0]         code;
    logic signed [15:0] pscore;
    logic [31:0]        move;
    logic signed [15:0] seval;
  } answer_t;

  typedef struct {
    logic [63:0] key;
    logic [7:0]  depth;
    logic [7:0]  gen;
    logic [6:0]  fifty;
    logic [7:0]  castling;
    int          score;
    int          seval;
    logic [31:0] move;
    logic [1:0]  bound;
  } slot_t;

  class cache_mirror;
    slot_t     slots [int];
    answer_t   due_answers [$];
    logic [7:0] gen;
    int        hi_thr;
    int        lo_thr;
    int        null_red;
    int        mismatches;

    function new();
      gen = 8'd0;
      hi_thr = 30000;
      lo_thr = -30000;
      null_red = 3;
      mismatches = 0;
    endfunction

    function void write_reg(logic [src_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] data);
      case (idx)
        src_pkg::CFG_GENERATION: gen = data[7:0];
        src_pkg::CFG_MATE_HIGH:  hi_thr = int'($signed(data));
        src_pkg::CFG_MATE_LOW:   lo_thr = int'($signed(data));
        src_pkg::CFG_NULL_RED:   null_red = int'(data[3:0]);
        default: ;
      endcase
    endfunction

    function int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function int pending();
      return due_answers.size();
    endfunction

    function void note_request(lookup_t r);
      answer_t a;
      slot_t   e;
      int      idx, v, p, dep, sd, ps, alpha, beta;
      logic [2:0] code;
      bit      match;
      a = '0;
      idx = int'(r.key[src_pkg::INDEX_BITS-1:0]);
      p = int'(r.ply);
      dep = int'(r.depth);
      alpha = r.alpha;
      beta = r.beta;
      match = 1'b0;
      if (slots.exists(idx)) begin
        e = slots[idx];
        match = e.gen == gen && e.key == r.key && e.fifty == r.fifty &&
                e.castling == r.castling;
      end
      if (r.op == src_pkg::OP_STORE) begin
        if (!(match && int'(e.depth) > dep)) begin
          v = r.score;
          if (v > hi_thr) v = clamp16(v + p);
          else if (v < lo_thr) v = clamp16(v - p);
          e.key = r.key;
          e.depth = r.depth;
          e.gen = gen;
          e.fifty = r.fifty;
          e.castling = r.castling;
          e.score = v;
          e.seval = r.seval;
          e.move = r.move;
          e.bound = r.bound;
          slots[idx] = e;
          a.written = 1'b1;
        end
      end else if (match) begin
        v = e.score;
        sd = int'(e.depth);
        code = src_pkg::CODE_NONE;
        ps = 0;
        if (v > hi_thr) v = clamp16(v - p);
        else if (v < lo_thr) v = clamp16(v + p);
        if (sd >= dep - null_red && v < beta && e.bound == src_pkg::BOUND_UPPER)
          code = src_pkg::CODE_AVOID_NULL;
        if (sd >= dep) begin
          if (e.bound == src_pkg::BOUND_UPPER && v <= alpha) begin
            code = src_pkg::CODE_UPPER;
            ps = alpha;
          end else if (e.bound == src_pkg::BOUND_LOWER && v >= beta) begin
            code = src_pkg::CODE_LOWER;
            ps = beta;
          end else if (e.bound == src_pkg::BOUND_EXACT) begin
            code = src_pkg::CODE_EXACT;
            ps = v;
          end
        end
        a.hit = 1'b1;
        a.code = code;
        a.pscore = 16'(ps);
        a.move = e.move;
        a.seval = 16'(e.seval);
      end
      due_answers.push_back(a);
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (due_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: written=%0d hit=%0d code=%0d score=%0d",
                   got.written, got.hit, got.code, got.pscore);
        return;
      end
      want = due_answers.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected written=%0d hit=%0d code=%0d score=%0d move=%h eval=%0d",
                   want.written, want.hit, want.code, want.pscore, want.move, want.seval);
          $display("          actual   written=%0d hit=%0d code=%0d score=%0d move=%h eval=%0d",
                   got.written, got.hit, got.code, got.pscore, got.move, got.seval);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [src_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [src_pkg::CFG_DATA_W-1:0]  cfg_data;

  src_req_if req_ch ();
  src_rsp_if rsp_ch ();

  search_result_cache i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  cache_mirror mirror = new();

  logic [63:0] key_pool    [KEYS];
  logic [6:0]  fifty_pool  [KEYS];
  logic [7:0]  castle_pool [KEYS];
  int          req_calm = 0;
  int          rsp_calm = 0;
  int          hold_cycles = 0;
  int          idle_cycles = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic lookup_t mk(logic op, logic [63:0] key, int fifty, int castling,
                                 int depth, int ply, int score, logic [1:0] bound,
                                 logic [31:0] move, int seval, int alpha, int beta);
    lookup_t r;
    r = '{op, key, 7'(fifty), 8'(castling), 8'(depth), 7'(ply), 16'(score), bound, move,
          16'(seval), 16'(alpha), 16'(beta)};
    return r;
  endfunction

  function automatic lookup_t random_lookup();
    lookup_t r;
    int k;
    k = $urandom_range(0, KEYS - 1);
    r.op = ($urandom_range(0, 99) < 45) ? src_pkg::OP_STORE : src_pkg::OP_PROBE;
    r.key = key_pool[k];
    if ($urandom_range(0, 9) == 0) r.key = {$urandom, $urandom};
    r.fifty = ($urandom_range(0, 5) == 0) ? 7'($urandom) : fifty_pool[k];
    r.castling = ($urandom_range(0, 5) == 0) ? 8'($urandom) : castle_pool[k];
    r.depth = 8'($urandom);
    r.ply = 7'($urandom);
    case ($urandom_range(0, 4))
      0: r.score = 16'(mirror.hi_thr + $urandom_range(0, 400) - 200);
      1: r.score = 16'(mirror.lo_thr + $urandom_range(0, 400) - 200);
      2: r.score = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: r.score = 16'($urandom);
    endcase
    r.bound = ($urandom_range(0, 9) == 0) ? BOUND_SPARE : 2'($urandom_range(0, 2));
    r.move = $urandom;
    r.seval = 16'($urandom);
    if ($urandom_range(0, 1)) begin
      r.alpha = 16'($urandom);
      r.beta = 16'($urandom);
    end else begin
      r.alpha = 16'(r.score + $urandom_range(0, 300) - 150);
      r.beta = 16'(r.score + $urandom_range(0, 300) - 150);
    end
    return r;
  endfunction

  task automatic send_request(input lookup_t r);
    int gap;
    gap = draw_gap(req_calm);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.operation      <= r.op;
    req_ch.position_key   <= r.key;
    req_ch.fifty_count    <= r.fifty;
    req_ch.castling_state <= r.castling;
    req_ch.search_depth   <= r.depth;
    req_ch.ply            <= r.ply;
    req_ch.score          <= r.score;
    req_ch.bound_kind     <= r.bound;
    req_ch.best_move      <= r.move;
    req_ch.static_eval    <= r.seval;
    req_ch.alpha          <= r.alpha;
    req_ch.beta           <= r.beta;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    mirror.note_request(r);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] gen, input int hi, input int lo,
                            input logic [3:0] nr);
    logic [src_pkg::CFG_INDEX_W-1:0] idx [4];
    logic [15:0]                     val [4];
    idx[0] = src_pkg::CFG_GENERATION;
    idx[1] = src_pkg::CFG_MATE_HIGH;
    idx[2] = src_pkg::CFG_MATE_LOW;
    idx[3] = src_pkg::CFG_NULL_RED;
    val[0] = {8'($urandom), gen};
    val[1] = 16'(hi);
    val[2] = 16'(lo);
    val[3] = {12'($urandom), nr};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      mirror.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count);
    repeat (count) send_request(random_lookup());
    drain();
  endtask

  task automatic directed_checks();
    logic [63:0] ka, kb, kc, kd, ke, kalias;
    ka = 64'h0123_4567_89ab_0042;
    kalias = 64'hfedc_ba98_7654_0042;
    kb = 64'h5555_aaaa_0f0f_1234;
    kc = 64'h8000_0000_0000_7777;
    kd = 64'h0000_0001_0000_8001;
    ke = 64'h3c3c_c3c3_1111_2222;
    send_request(mk(src_pkg::OP_PROBE, ka, 10, 3, 8, 0, 0, src_pkg::BOUND_UPPER,
                    0, 0, -100, 100));
    send_request(mk(src_pkg::OP_STORE, ka, 10, 3, 8, 5, 30500, src_pkg::BOUND_EXACT,
                    32'h1234_5678, -250, 0, 0));
    send_request(mk(src_pkg::OP_PROBE, ka, 10, 3, 8, 2, 0, src_pkg::BOUND_UPPER,
                    0, 0, -100, 100));
    send_request(mk(src_pkg::OP_PROBE, ka, 11, 3, 8, 2, 0, src_pkg::BOUND_UPPER,
                    0, 0, -100, 100));
    send_request(mk(src_pkg::OP_PROBE, ka, 10, 4, 8, 2, 0, src_pkg::BOUND_UPPER,
                    0, 0, -100, 100));
    send_request(mk(src_pkg::OP_PROBE, kalias, 10, 3, 8, 2, 0, src_pkg::BOUND_UPPER,
                    0, 0, -100, 100));
    send_request(mk(src_pkg::OP_STORE, ka, 10, 3, 5, 1, 77, src_pkg::BOUND_LOWER,
                    32'h1, 5, 0, 0));
    send_request(mk(src_pkg::OP_STORE, ka, 10, 3, 8, 7, -30500, src_pkg::BOUND_LOWER,
                    32'hcafe_0001, 42, 0, 0));
    send_request(mk(src_pkg::OP_PROBE, ka, 10, 3, 6, 3, 0, src_pkg::BOUND_UPPER,
                    0, 0, 0, -31000));
    send_request(mk(src_pkg::OP_STORE, kb, 0, 0, 10, 127, 32767, src_pkg::BOUND_UPPER,
                    32'h2, 7, 0, 0));
    send_request(mk(src_pkg::OP_PROBE, kb, 0, 0, 12, 0, 0, src_pkg::BOUND_UPPER,
                    0, 0, 0, 32767));
    send_request(mk(src_pkg::OP_STORE, kc, 1, 1, 10, 0, 100, src_pkg::BOUND_UPPER,
                    32'h3, -7, 0, 0));
    send_request(mk(src_pkg::OP_PROBE, kc, 1, 1, 12, 0, 0, src_pkg::BOUND_UPPER,
                    0, 0, 0, 500));
    send_request(mk(src_pkg::OP_PROBE, kc, 1, 1, 10, 0, 0, src_pkg::BOUND_UPPER,
                    0, 0, 200, 500));
    send_request(mk(src_pkg::OP_PROBE, kc, 1, 1, 14, 0, 0, src_pkg::BOUND_UPPER,
                    0, 0, 0, 500));
    send_request(mk(src_pkg::OP_STORE, kd, 2, 2, 20, 127, 16'sh8000, BOUND_SPARE,
                    32'h4, 9, 0, 0));
    send_request(mk(src_pkg::OP_PROBE, kd, 2, 2, 0, 127, 0, src_pkg::BOUND_UPPER,
                    0, 0, 16'sh8000, 16'sh7fff));
    send_request(mk(src_pkg::OP_STORE, '1, 127, 255, 255, 127, 16'sh8000,
                    src_pkg::BOUND_EXACT, '1, 16'sh7fff, 0, 0));
    send_request(mk(src_pkg::OP_PROBE, '1, 127, 255, 255, 127, 0, src_pkg::BOUND_UPPER,
                    0, 0, 16'sh8000, 16'sh7fff));
    send_request(mk(src_pkg::OP_STORE, '0, 0, 0, 0, 0, 0, src_pkg::BOUND_LOWER,
                    '0, 16'sh8000, 0, 0));
    send_request(mk(src_pkg::OP_PROBE, '0, 0, 0, 0, 0, 0, src_pkg::BOUND_UPPER,
                    0, 0, 0, 0));
    send_request(mk(src_pkg::OP_STORE, ka, 0, 3, 255, 4, 12, src_pkg::BOUND_UPPER,
                    32'h5, 1, 0, 0));
    send_request(mk(src_pkg::OP_STORE, ke, 5, 9, 30, 9, 30000, src_pkg::BOUND_EXACT,
                    32'h6, 2, 0, 0));
    send_request(mk(src_pkg::OP_PROBE, ke, 5, 9, 30, 9, 0, src_pkg::BOUND_UPPER,
                    0, 0, 0, 0));
  endtask

  initial begin : answer_sink
    int      gap;
    answer_t got;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = draw_gap(rsp_calm);
      end
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (rsp_ch.valid !== 1'b1) @(posedge clk);
      got.written = rsp_ch.written;
      got.hit     = rsp_ch.hit;
      got.code    = rsp_ch.probe_code;
      got.pscore  = rsp_ch.probe_score;
      got.move    = rsp_ch.hit_move;
      got.seval   = rsp_ch.hit_static_eval;
      mirror.check_answer(got);
    end
  end

  initial begin : request_source
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= src_pkg::CFG_GENERATION;
    cfg_data              <= '0;
    req_ch.valid          <= 1'b0;
    req_ch.operation      <= src_pkg::OP_PROBE;
    req_ch.position_key   <= '0;
    req_ch.fifty_count    <= '0;
    req_ch.castling_state <= '0;
    req_ch.search_depth   <= '0;
    req_ch.ply            <= '0;
    req_ch.score          <= '0;
    req_ch.bound_kind     <= src_pkg::BOUND_UPPER;
    req_ch.best_move      <= '0;
    req_ch.static_eval    <= '0;
    req_ch.alpha          <= '0;
    req_ch.beta           <= '0;
    for (int i = 0; i < KEYS; i++) begin
      key_pool[i] = (i < 24) ? {$urandom, $urandom}
                             : {32'($urandom), 16'($urandom), key_pool[i - 24][15:0]};
      fifty_pool[i] = 7'($urandom);
      castle_pool[i] = 8'($urandom);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_config(8'd0, 30000, -30000, 4'd3);
    directed_checks();
    drain();

    hold_cycles = HOLD_LONG;
    run_random(PHASE_ITEMS);
    set_config(8'd255, 32767, -32768, 4'd15);
    run_random(PHASE_ITEMS);
    set_config(8'd0, -32768, 32767, 4'd0);
    run_random(PHASE_ITEMS);
    set_config(8'd1, 100, -100, 4'd7);
    run_random(PHASE_ITEMS);
    set_config(8'd255, $urandom_range(0, 32767), -int'($urandom_range(0, 32768)),
               4'($urandom));
    run_random(PHASE_ITEMS);
    set_config(8'd0, 30000, -30000, 4'd3);
    run_random(PHASE_ITEMS);

    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
